/* sv/icwm_pkg.sv */
// Shared types and constants of the IR carrier word modulator.
`default_nettype none

package icwm_pkg;

  localparam int DURATION_BITS = 24;
  localparam int WORD_BITS     = 16;
  localparam int CARRIER_BITS  = 20;
  localparam int DUTY_BITS     = 7;
  localparam int REMAIN_BITS   = 25;
  localparam int REG_IDX_BITS  = 2;

  localparam logic [CARRIER_BITS-1:0] CARRIER_RESET = 20'd38000;
  localparam logic [DUTY_BITS-1:0]    DUTY_RESET    = 7'd50;

  localparam logic [REG_IDX_BITS-1:0] REG_CARRIER_HZ   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DUTY_PERCENT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_ACTIVE_LOW   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Cycle count arithmetic: round(duration * carrier / 1e6), where
  // 1e6 = 64 * 15625 and the odd factor is removed by a reciprocal.
  localparam int PROD_BITS   = DURATION_BITS + CARRIER_BITS;
  localparam int SUM_BITS    = PROD_BITS + 1;
  localparam int US_PER_S    = 1000000;
  localparam int HALF_US     = US_PER_S / 2;
  localparam int PRE_SHIFT   = 6;
  localparam int DIV_ODD     = US_PER_S / (1 << PRE_SHIFT);
  localparam int NSH_BITS    = SUM_BITS - PRE_SHIFT;
  localparam int RECIP_SHIFT = NSH_BITS + 14;
  localparam int RECIP_BITS  = NSH_BITS + 1;
  localparam int LO_BITS     = 20;
  localparam int PP_BITS     = 2 * LO_BITS;
  localparam int TOT_BITS    = NSH_BITS + RECIP_BITS;

  localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);
  localparam logic [63:0] SAT_LIMIT = (64'd1 << REMAIN_BITS) * 64'(US_PER_S);

  typedef struct packed {
    logic                     operation;
    logic [DURATION_BITS-1:0] duration_us;
    logic                     end_of_burst;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 word_valid;
    logic                 segment_done;
    logic                 burst_done;
    logic                 overrun;
  } out_item_t;

  typedef struct packed {
    logic                   operation;
    logic [REMAIN_BITS-1:0] cycles;
    logic                   end_of_burst;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty_percent;
    logic                 active_low;
  } word_cfg_t;

endpackage

`default_nettype wire

/* sv/ir_carrier_word_modulator.sv */
// Top level of the IR carrier word modulator.
// Every input item, load or tick, gives exactly one result, in order. Items are taken one per
// clock while full is low; a result reaches the output ports through the five-stage front
// pipeline that multiplies the duration by the carrier and divides by one million through a split
// reciprocal multiply, then the command queue and the back end that holds the segment state and
// forms the result combinationally into the output queue. Sustained rate is one item per cycle while
// results are popped; full rises only when the command queue backs up into the front pipeline.
`default_nettype none

module ir_carrier_word_modulator #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  icwm_pkg::in_item_t                  item,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output icwm_pkg::out_item_t                 result,
  input  logic                                cfg_we,
  input  logic [icwm_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [icwm_pkg::CARRIER_BITS-1:0]   cfg_data
);

  import icwm_pkg::*;

  logic [CARRIER_BITS-1:0] carrier_hz;
  logic [DUTY_BITS-1:0]    duty_percent;
  logic                    active_low;
  word_cfg_t               settings;

  cmd_t      front_cmd, back_cmd;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  out_item_t back_res;
  logic      res_push, res_full;

  assign settings = '{duty_percent: duty_percent, active_low: active_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_hz   <= CARRIER_RESET;
      duty_percent <= DUTY_RESET;
      active_low   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CARRIER_HZ: begin
          if (cfg_data != '0) begin
            carrier_hz <= cfg_data;
          end
        end
        REG_DUTY_PERCENT: begin
          duty_percent <= cfg_data[DUTY_BITS-1:0];
        end
        REG_ACTIVE_LOW: begin
          active_low <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  icwm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .carrier_hz (carrier_hz),
    .cmd        (front_cmd),
    .cmd_push   (cmd_push),
    .cmd_full   (cmd_full)
  );

  icwm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  icwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .settings  (settings),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  icwm_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

/* sv/icwm_fifo.sv */
// Small register queue with the head shown while not empty.
`default_nettype none

module icwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* sv/icwm_front.sv */
// Front pipeline: takes items and converts load durations to carrier cycles.
`default_nettype none

module icwm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  icwm_pkg::in_item_t                   item,
  output logic                                 full,
  input  logic [icwm_pkg::CARRIER_BITS-1:0]    carrier_hz,
  output icwm_pkg::cmd_t                       cmd,
  output logic                                 cmd_push,
  input  logic                                 cmd_full
);

  import icwm_pkg::*;

  logic en;

  logic                     s1_valid, s1_op, s1_eob;
  logic [DURATION_BITS-1:0] s1_dur;
  logic                     s2_valid, s2_op, s2_eob;
  logic [PROD_BITS-1:0]     s2_prod;
  logic                     s3_valid, s3_op, s3_eob, s3_sat;
  logic [NSH_BITS-1:0]      s3_quo;
  logic                     s4_valid, s4_op, s4_eob, s4_sat;
  logic [PP_BITS-1:0]       s4_hh, s4_hl, s4_lh, s4_ll;
  logic                     s5_valid, s5_op, s5_eob;
  logic [REMAIN_BITS-1:0]   s5_cycles;

  logic [SUM_BITS-1:0]      sum;
  logic [TOT_BITS-1:0]      total;

  assign en       = !(s5_valid && cmd_full);
  assign full     = !en;
  assign cmd_push = s5_valid && !cmd_full;
  assign cmd      = '{operation: s5_op, cycles: s5_cycles, end_of_burst: s5_eob};

  assign sum   = SUM_BITS'(s2_prod) + SUM_BITS'(HALF_US);
  assign total = (TOT_BITS'(s4_hh) << PP_BITS) + (TOT_BITS'(s4_hl) << LO_BITS)
               + (TOT_BITS'(s4_lh) << LO_BITS) + TOT_BITS'(s4_ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= item.operation;
      s1_dur <= item.duration_us;
      s1_eob <= item.end_of_burst;

      s2_op   <= s1_op;
      s2_eob  <= s1_eob;
      s2_prod <= PROD_BITS'(s1_dur) * PROD_BITS'(carrier_hz);

      s3_op  <= s2_op;
      s3_eob <= s2_eob;
      s3_sat <= (64'(sum) >= SAT_LIMIT);
      s3_quo <= sum[SUM_BITS-1:PRE_SHIFT];

      s4_op  <= s3_op;
      s4_eob <= s3_eob;
      s4_sat <= s3_sat;
      s4_hh  <= PP_BITS'(s3_quo[NSH_BITS-1:LO_BITS]) * PP_BITS'(RECIP[RECIP_BITS-1:LO_BITS]);
      s4_hl  <= PP_BITS'(s3_quo[NSH_BITS-1:LO_BITS]) * PP_BITS'(RECIP[LO_BITS-1:0]);
      s4_lh  <= PP_BITS'(s3_quo[LO_BITS-1:0]) * PP_BITS'(RECIP[RECIP_BITS-1:LO_BITS]);
      s4_ll  <= PP_BITS'(s3_quo[LO_BITS-1:0]) * PP_BITS'(RECIP[LO_BITS-1:0]);

      s5_op     <= s4_op;
      s5_eob    <= s4_eob;
      s5_cycles <= s4_sat ? '1 : total[RECIP_SHIFT +: REMAIN_BITS];
    end
  end

endmodule

`default_nettype wire

/* sv/icwm_back.sv */
// Back end: segment state, word generation and result formation.
`default_nettype none

module icwm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  icwm_pkg::cmd_t       cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  icwm_pkg::word_cfg_t  settings,
  output icwm_pkg::out_item_t  res,
  output logic                 res_push,
  input  logic                 res_full
);

  import icwm_pkg::*;

  localparam logic [21:0] DIV100_RECIP = 22'd1311;

  logic [REMAIN_BITS-1:0] remaining, remaining_next;
  logic                   seg_space, seg_space_next;
  logic                   next_space, next_space_next;
  logic                   seg_eob, seg_eob_next;

  logic [10:0]            duty15;
  logic [21:0]            ones_prod;
  logic [4:0]             ones;
  logic [WORD_BITS-1:0]   pulse_raw;
  logic [WORD_BITS-1:0]   pulse_w;
  logic [WORD_BITS-1:0]   space_w;

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;

  assign duty15    = 11'(settings.duty_percent) * 11'd15;
  assign ones_prod = 22'(duty15) * DIV100_RECIP;
  assign ones      = ones_prod[21:17] + 5'd1;
  assign pulse_raw = (ones >= 5'(WORD_BITS)) ? '1
                   : WORD_BITS'((17'd1 << ones) - 17'd1);
  assign pulse_w   = settings.active_low ? ~pulse_raw : pulse_raw;
  assign space_w   = settings.active_low ? '1 : '0;

  always_comb begin
    remaining_next  = remaining;
    seg_space_next  = seg_space;
    next_space_next = next_space;
    seg_eob_next    = seg_eob;
    res             = '{word: space_w, word_valid: 1'b0, segment_done: 1'b0,
                        burst_done: 1'b0, overrun: 1'b0};
    case (cmd.operation)
      OP_LOAD: begin
        res.overrun     = (remaining != '0);
        remaining_next  = cmd.cycles;
        seg_space_next  = next_space;
        seg_eob_next    = cmd.end_of_burst;
        next_space_next = cmd.end_of_burst ? 1'b0 : !next_space;
      end
      OP_TICK: begin
        if (remaining != '0) begin
          res.word       = seg_space ? space_w : pulse_w;
          res.word_valid = 1'b1;
          remaining_next = remaining - REMAIN_BITS'(1);
          if (remaining == REMAIN_BITS'(1)) begin
            res.segment_done = 1'b1;
            res.burst_done   = seg_eob;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      seg_space  <= 1'b0;
      next_space <= 1'b0;
      seg_eob    <= 1'b0;
    end else if (cmd_pop) begin
      remaining  <= remaining_next;
      seg_space  <= seg_space_next;
      next_space <= next_space_next;
      seg_eob    <= seg_eob_next;
    end
  end

endmodule

`default_nettype wire

/* sv/icwm_checker.sv */
// Port-level checks of the IR carrier word modulator and their binding.
`default_nettype none

module icwm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                push,
  input icwm_pkg::in_item_t                  item,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input icwm_pkg::out_item_t                 result,
  input logic                                cfg_we,
  input logic [icwm_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input logic [icwm_pkg::CARRIER_BITS-1:0]   cfg_data
);

  import icwm_pkg::*;

  logic unused_inputs;
  assign unused_inputs = push ^ (^item) ^ cfg_we ^ (^cfg_index) ^ (^cfg_data);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (!(result.overrun && result.word_valid)
                  && (!result.segment_done || result.word_valid)
                  && (!result.burst_done || result.segment_done)))
    else $error("inconsistent result flags");

  a_idle_word: assert property (@(posedge clk) disable iff (rst)
      (!empty && !result.word_valid) |-> (result.word == '0 || result.word == '1))
    else $error("non-word slot carries a pulse pattern");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before its transfer");

endmodule

bind ir_carrier_word_modulator icwm_checker u_checker (.*);

`default_nettype wire
